FILE: rtl/core/swi_pkg.sv
package swi_pkg;

   localparam int VALUE_W = 16;
   localparam int SLOT_W  = 3;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   // Per-beat command broadcast from the top level to every cell.
   typedef struct packed {
      logic               load;
      logic               ins_low;
      logic               ins_high;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/swi_req_if.sv
interface swi_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [2:0]  slot;
   logic [15:0] value;

   modport source (output valid, output mode, output slot, output value, input ready);
   modport sink (input valid, input mode, input slot, input value, output ready);
endinterface

interface swi_rsp_if;
   logic        valid;
   logic        ready;
   logic        inserted;
   logic [2:0]  position;
   logic        went_high;
   logic [15:0] dropped_value;

   modport source (output valid, output inserted, output position, output went_high,
                   output dropped_value, input ready);
   modport sink (input valid, input inserted, input position, input went_high,
                 input dropped_value, output ready);
endinterface

FILE: rtl/core/swi_cell.sv
module swi_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swi_pkg::cell_ctrl_type ctrl,
   input  logic [15:0]            prev_entry,
   input  logic [15:0]            next_entry,
   input  logic                   below_in,
   input  logic                   above_in,
   output logic                   below_out,
   output logic                   above_out,
   output logic                   hit,
   output logic [15:0]            entry
);
   import swi_pkg::*;

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               gt;
   logic               lt;
   logic               hit_low;
   logic               hit_high;
   logic               load_hit;

   assign gt = entry_ff > ctrl.value;
   assign lt = (INDEX != 0) && (entry_ff < ctrl.value);

   // Low side looks for the first larger entry from slot 0 up, the high side
   // for the last smaller entry from the top down; the chains carry "found".
   assign hit_low   = gt && !below_in;
   assign hit_high  = lt && !above_in;
   assign below_out = below_in || gt;
   assign above_out = above_in || lt;
   assign load_hit  = ctrl.load && (INDEX < 8) && (ctrl.slot == SLOT_W'(INDEX));

   assign hit = (ctrl.ins_low && hit_low) || (ctrl.ins_high && hit_high);

   always_comb begin
      entry_in = entry_ff;
      if (load_hit) begin
         entry_in = ctrl.value;
      end else if (ctrl.ins_low) begin
         if (hit_low) begin
            entry_in = ctrl.value;
         end else if (below_in) begin
            entry_in = prev_entry;
         end
      end else if (ctrl.ins_high) begin
         if (hit_high) begin
            entry_in = ctrl.value;
         end else if (above_in) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/core/sorted_window_insert_evict_core.sv
// Sorted window with end eviction.
// The req channel carries one command beat: mode (load or insert), slot and a
// 16-bit value. A load writes the value straight into the named slot; an
// insert places the value in order, evicting the top entry when it lands
// below the median slot and slot 0 when it lands at or above it.
// The rsp channel returns exactly one beat per command: inserted, position,
// went_high and dropped_value.
// The result beat is registered and valid in the cycle after the command beat
// is accepted. Throughput is one beat per cycle when not stalled, set by the
// row of cells, each of which compares its entry with the value and shifts in
// a neighbor entry in the same cycle; the found flags ripple along the row.
// A synchronous reset clears every slot to zero and drops any pending result.
// When the receiver stalls, the pending result is held in the output
// register and the block still takes a new command in the cycle that the
// held beat is taken.
module sorted_window_insert_evict_core #(
   parameter int SLOT_COUNT = 8
) (
   input logic      clock,
   input logic      reset,
   swi_req_if.sink  req,
   swi_rsp_if.source rsp
);
   import swi_pkg::*;

   localparam int MEDIAN = SLOT_COUNT / 2;

   logic [VALUE_W-1:0] entry [SLOT_COUNT];
   logic [VALUE_W-1:0] ext [SLOT_COUNT+2];
   logic               below [SLOT_COUNT+1];
   logic               above [SLOT_COUNT+1];
   logic [SLOT_COUNT-1:0] hit_vec;

   cell_ctrl_type      ctrl;
   logic               accept;
   logic               below_median;
   logic               found;
   logic [SLOT_W-1:0]  hit_pos;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               inserted_ff;
   logic               inserted_in;
   logic [SLOT_W-1:0]  position_ff;
   logic [SLOT_W-1:0]  position_in;
   logic               went_high_ff;
   logic               went_high_in;
   logic [VALUE_W-1:0] dropped_ff;
   logic [VALUE_W-1:0] dropped_in;

   // A new beat is taken whenever the output register is empty or is being
   // emptied in this cycle.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign below_median  = req.value < entry[MEDIAN];
   assign ctrl.load     = accept && (req.mode == MODE_LOAD);
   assign ctrl.ins_low  = accept && (req.mode == MODE_INSERT) && below_median;
   assign ctrl.ins_high = accept && (req.mode == MODE_INSERT) && !below_median;
   assign ctrl.slot     = req.slot;
   assign ctrl.value    = req.value;

   // Edge entries feed zeros; a cell at either end never takes that neighbor.
   assign ext[0]            = '0;
   assign ext[SLOT_COUNT+1] = '0;
   assign below[0]          = 1'b0;
   assign above[SLOT_COUNT] = 1'b0;

   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      assign ext[k+1] = entry[k];

      swi_cell #(
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (ext[k]),
         .next_entry (ext[k+2]),
         .below_in   (below[k]),
         .above_in   (above[k+1]),
         .below_out  (below[k+1]),
         .above_out  (above[k]),
         .hit        (hit_vec[k]),
         .entry      (entry[k])
      );
   end

   // At most one cell hits, so OR-ing the indexes of hitting cells encodes it.
   always_comb begin
      hit_pos = '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         if (hit_vec[k]) begin
            hit_pos = hit_pos | SLOT_W'(k);
         end
      end
   end

   assign found = |hit_vec;

   always_comb begin
      inserted_in  = found;
      went_high_in = ctrl.ins_high;
      position_in  = ctrl.load ? req.slot : hit_pos;
      dropped_in   = '0;
      if (ctrl.ins_low) begin
         dropped_in = entry[SLOT_COUNT-1];
      end else if (ctrl.ins_high && found) begin
         dropped_in = entry[0];
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         inserted_ff  <= inserted_in;
         position_ff  <= position_in;
         went_high_ff <= went_high_in;
         dropped_ff   <= dropped_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.inserted      = inserted_ff;
   assign rsp.position      = position_ff;
   assign rsp.went_high     = went_high_ff;
   assign rsp.dropped_value = dropped_ff;

`ifndef SYNTHESIS
   a_hit_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell claimed the insert slot");

   a_low_always_found: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_low |-> found)
      else $error("low-side insert found no larger entry");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted command produced no result beat");

   a_load_no_hit: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> !found)
      else $error("load command reported an insert");
`endif

endmodule

FILE: tb/sorted_window_insert_evict_core_tb.sv
`timescale 1ns / 1ps

// Checks the sorted window with end eviction. Command beats go in on the req
// channel and every beat is mirrored into a software copy of the eight-slot
// window. That copy works out the response beat which the block must return.
// The rsp channel is compared field by field, in order, against those
// predictions.
module sorted_window_insert_evict_core_tb;
   import swi_pkg::*;

   localparam int SLOTS      = 8;
   localparam int LONG_HOLD  = 60;   // countdown loaded when the receiver is asked to refuse beats
   localparam int PHASE_LEN  = 150;  // random picks per idling phase (a full ascending load counts as one)
   localparam int DRAIN_WAIT = 4;    // idle wait after the last expected response

   // One response beat, in the order the rsp channel carries its fields.
   typedef struct packed {
      logic               inserted;
      logic [SLOT_W-1:0]  position;
      logic               went_high;
      logic [VALUE_W-1:0] dropped_value;
   } window_result_type;

   // Software copy of the window, plus the queue of responses that it has
   // predicted and the block has not yet returned.
   class window_checker;
      logic [VALUE_W-1:0] window [SLOTS];
      window_result_type  expected_results [$];
      int                 errors;

      function new();
         foreach (window[i]) window[i] = '0;
         errors = 0;
      endfunction

      // Applies one accepted command beat to the copy and queues its response.
      function void note_command(logic mode, logic [SLOT_W-1:0] slot,
                                 logic [VALUE_W-1:0] value);
         window_result_type r;
         r = '0;
         if (mode == MODE_LOAD) begin
            // A load writes straight into the slot and reports only the slot.
            window[slot] = value;
            r.position = slot;
         end else if (value < window[SLOTS/2]) begin
            // Below the median: land in front of the first larger entry, shift
            // the upper part up and lose the top entry. The median itself is
            // larger, so a place is always found.
            for (int i = 0; i < SLOTS; i++) begin
               if (!r.inserted && window[i] > value) begin
                  r.dropped_value = window[SLOTS-1];
                  for (int n = SLOTS - 1; n > i; n--) window[n] = window[n-1];
                  window[i]  = value;
                  r.inserted = 1'b1;
                  r.position = i[SLOT_W-1:0];
               end
            end
         end else begin
            // At or above the median: land at the highest slot holding a
            // smaller entry, shift the lower part down and lose slot 0. When
            // slots 7 down to 1 hold nothing smaller, the window stays as is.
            r.went_high = 1'b1;
            for (int i = SLOTS - 1; i > 0; i--) begin
               if (!r.inserted && window[i] < value) begin
                  r.dropped_value = window[0];
                  for (int n = 0; n < i; n++) window[n] = window[n+1];
                  window[i]  = value;
                  r.inserted = 1'b1;
                  r.position = i[SLOT_W-1:0];
               end
            end
         end
         expected_results.push_back(r);
      endfunction

      // Compares one accepted response beat with the oldest prediction.
      function void check_result(window_result_type got);
         window_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: response beat with nothing expected: %h", $time, got);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (got.inserted !== want.inserted) begin
            $display("%0t: inserted expected %0d actual %0d",
                     $time, want.inserted, got.inserted);
            errors++;
         end
         if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, got.position);
            errors++;
         end
         if (got.went_high !== want.went_high) begin
            $display("%0t: went_high expected %0d actual %0d",
                     $time, want.went_high, got.went_high);
            errors++;
         end
         if (got.dropped_value !== want.dropped_value) begin
            $display("%0t: dropped_value expected %h actual %h",
                     $time, want.dropped_value, got.dropped_value);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   swi_req_if req_bus ();
   swi_rsp_if rsp_bus ();

   sorted_window_insert_evict_core #(.SLOT_COUNT(SLOTS)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   window_checker board = new();

   // Idling controls. The sender and the receiver each skip a cycle with the
   // given chance in a hundred. A change of hold_tag asks the receiver for one
   // long stretch of refusing beats.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_tag      = 0;
   int seen_hold_tag = 0;
   int hold_left     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver. Ready is set anew through a register at every rising edge. A long
   // hold is counted down here, so the sender keeps offering beats meanwhile
   // and the block has to fill its output register and push back.
   always @(posedge clock) begin
      if (hold_tag != seen_hold_tag) begin
         seen_hold_tag <= hold_tag;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Response monitor. Values read right at the edge are the ones that the
   // edge sampled, since everything around them changes through nonblocking
   // updates.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result({rsp_bus.inserted, rsp_bus.position,
                             rsp_bus.went_high, rsp_bus.dropped_value});
   end

   // Offers one command beat and returns at the edge that accepts it. When
   // the sender idles, valid drops for a random number of cycles first.
   // Otherwise valid stays high straight into the next beat.
   task automatic send_command(input logic mode, input logic [SLOT_W-1:0] slot,
                               input logic [VALUE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.slot  <= slot;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      board.note_command(mode, slot, value);
   endtask

   // Sample values are spread over the full range, a cluster near zero and a
   // cluster near the top, so that ties with stored entries happen often.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0:       pick_value = VALUE_W'($urandom_range(15));
         1:       pick_value = VALUE_W'(16'hFFFF - $urandom_range(15));
         default: pick_value = VALUE_W'($urandom);
      endcase
   endfunction

   // Refills the window with an ascending run from a random base, so that
   // later inserts meet a well-ordered list with known spacing.
   task automatic load_ascending();
      logic [VALUE_W-1:0] base;
      int                 step;
      base = VALUE_W'($urandom_range(16'hF000));
      step = int'($urandom_range(1, 500));
      for (int s = 0; s < SLOTS; s++)
         send_command(MODE_LOAD, s[SLOT_W-1:0], VALUE_W'(base + s * step));
   endtask

   task automatic random_phase(input int idle_pct, input int stall, input bit with_hold);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (with_hold)
         hold_tag <= hold_tag + 1;
      for (int k = 0; k < PHASE_LEN; k++) begin
         case ($urandom_range(19))
            0:       load_ascending();
            1, 2:    send_command(MODE_LOAD, SLOT_W'($urandom), pick_value());
            default: send_command(MODE_INSERT, SLOT_W'($urandom), pick_value());
         endcase
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_LOAD;
      req_bus.slot  = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The window starts all zeros, so an insert of zero is
      // not below the median but finds no smaller entry: no change at all.
      send_command(MODE_INSERT, 3'd0, 16'h0000);
      // The largest value lands in the top slot and slot 0 drops out.
      send_command(MODE_INSERT, 3'd7, 16'hFFFF);
      // A clean ascending list through every slot.
      for (int s = 0; s < SLOTS; s++)
         send_command(MODE_LOAD, s[SLOT_W-1:0], VALUE_W'(100 * (s + 1)));
      // Below the median at the very bottom: the top entry is evicted.
      send_command(MODE_INSERT, 3'd5, 16'd50);
      // Below the median in the middle of the lower half.
      send_command(MODE_INSERT, 3'd0, 16'd250);
      // Equal to the median counts as not below it.
      send_command(MODE_INSERT, 3'd2, 16'd300);
      // Above everything: lands at the top, slot 0 is evicted.
      send_command(MODE_INSERT, 3'd6, 16'd900);
      // Zero is below the median and goes in front of everything.
      send_command(MODE_INSERT, 3'd1, 16'h0000);
      // Full-scale loads, then inserts on either side of a full-scale median.
      send_command(MODE_LOAD, 3'd7, 16'hFFFF);
      send_command(MODE_LOAD, 3'd4, 16'hFFFF);
      send_command(MODE_INSERT, 3'd4, 16'hFFFE);
      send_command(MODE_INSERT, 3'd3, 16'hFFFF);
      // Alternating bit patterns in the value and a load of zero.
      send_command(MODE_LOAD, 3'd5, 16'hAAAA);
      send_command(MODE_LOAD, 3'd2, 16'h0000);
      send_command(MODE_INSERT, 3'd7, 16'h5555);
      send_command(MODE_INSERT, 3'd0, 16'hAAAA);

      // Random part, one phase per idling pattern. The first and third phases also
      // hold off the receiver for a long stretch while the sender runs at full rate.
      random_phase(0, 0, 1'b1);
      random_phase(63, 0, 1'b0);
      random_phase(0, 63, 1'b1);
      random_phase(7, 7, 1'b0);

      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (board.errors == 0)
         $display("sorted_window_insert_evict_core test passed");
      else
         $display("sorted_window_insert_evict_core test failed");
      $finish;
   end

   // Far beyond the slowest legal run of this stimulus.
   initial begin
      #2_000_000;
      $display("sorted_window_insert_evict_core test failed");
      $finish;
   end

endmodule

FILE: sorted_window_insert_evict_core.f
rtl/core/swi_pkg.sv
rtl/core/swi_req_if.sv
rtl/core/swi_cell.sv
rtl/core/sorted_window_insert_evict_core.sv
tb/sorted_window_insert_evict_core_tb.sv
